[hw/rtl/clipped_rect_blit_rows_defines.svh]
// Assertion macros used by the row generator datapath.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CLIPPED_RECT_BLIT_ROWS_DEFINES_SVH
`define CLIPPED_RECT_BLIT_ROWS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/crb_pkg.sv]
package crb_pkg;

    // Default size limits. The ports are sized for 256 x 64.
    localparam int CRB_MAX_WIDTH  = 256;
    localparam int CRB_MAX_HEIGHT = 64;

    // Fixed field widths.
    localparam int CRB_WW  = 9;   // widths in pixels
    localparam int CRB_HW  = 7;   // heights in rows
    localparam int CRB_OW  = 14;  // linear offsets
    localparam int CRB_CW  = 20;  // signed edge arithmetic
    localparam int CRB_IDW = 144; // slave tdata
    localparam int CRB_ODW = 72;  // master tdata

    localparam logic [CRB_WW-1:0] CRB_DST_WIDTH_RST  = 9'd256;
    localparam logic [CRB_HW-1:0] CRB_DST_HEIGHT_RST = 7'd64;

    // Configuration register indexes.
    localparam logic CFG_DST_WIDTH  = 1'b0;
    localparam logic CFG_DST_HEIGHT = 1'b1;

    // Axis selector in the control word.
    localparam logic AX_X = 1'b0;
    localparam logic AX_Y = 1'b1;

    typedef logic [3:0] t_step;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_WAIT  = 4'd1,
        OP_BOUND = 4'd2,
        OP_PLACE = 4'd3,
        OP_DEST  = 4'd4,
        OP_TRIM  = 4'd5,
        OP_MUL   = 4'd6,
        OP_BASE  = 4'd7,
        OP_EMIT  = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_INPUT  = 3'd2,
        C_EMPTY     = 3'd3,
        C_ROWS_LEFT = 3'd4
    } t_cond;

    typedef struct packed {
        t_op   op;
        logic  axis;
        t_cond hold;
        t_cond jcond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic empty;
        logic rows_left;
    } t_stat;

    localparam t_step STEP_WAIT = 4'd0;
    localparam t_step STEP_EMIT = 4'd11;

    // Control store. A held step repeats; otherwise a true jump condition
    // loads the target and anything else falls through to the next step.
    function automatic t_uword crb_ucode(input t_step pc);
        t_uword w;
        w = '{op: OP_NOP, axis: AX_X, hold: C_NEVER, jcond: C_ALWAYS,
              target: STEP_WAIT};
        case (pc)
            4'd0: w = '{op: OP_WAIT, axis: AX_X, hold: C_NO_INPUT, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd1: w = '{op: OP_BOUND, axis: AX_X, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd2: w = '{op: OP_PLACE, axis: AX_X, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd3: w = '{op: OP_DEST, axis: AX_X, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd4: w = '{op: OP_TRIM, axis: AX_X, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd5: w = '{op: OP_BOUND, axis: AX_Y, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd6: w = '{op: OP_PLACE, axis: AX_Y, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd7: w = '{op: OP_DEST, axis: AX_Y, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd8: w = '{op: OP_TRIM, axis: AX_Y, hold: C_NEVER, jcond: C_EMPTY,
                        target: STEP_WAIT};
            4'd9: w = '{op: OP_MUL, axis: AX_X, hold: C_NEVER, jcond: C_NEVER,
                        target: STEP_WAIT};
            4'd10: w = '{op: OP_BASE, axis: AX_X, hold: C_NEVER, jcond: C_NEVER,
                         target: STEP_WAIT};
            4'd11: w = '{op: OP_EMIT, axis: AX_X, hold: C_ROWS_LEFT, jcond: C_ALWAYS,
                         target: STEP_WAIT};
            default: w = '{op: OP_NOP, axis: AX_X, hold: C_NEVER, jcond: C_ALWAYS,
                           target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/crb_seq.sv]
module crb_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crb_pkg::t_stat  i_stat,
    output crb_pkg::t_uword o_ctrl
);
    import crb_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_word;

    function automatic logic cond_true(input t_cond c, input t_stat st);
        logic res;
        case (c)
            C_NEVER:     res = 1'b0;
            C_ALWAYS:    res = 1'b1;
            C_NO_INPUT:  res = !st.in_valid;
            C_EMPTY:     res = st.empty;
            C_ROWS_LEFT: res = st.rows_left;
            default:     res = 1'b0;
        endcase
        return res;
    endfunction

    assign w_word = crb_ucode(r_pc);
    assign o_ctrl = w_word;

    always_comb begin
        if (cond_true(w_word.hold, i_stat)) begin
            n_pc = r_pc;
        end else if (cond_true(w_word.jcond, i_stat)) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hw/rtl/crb_dpath.sv]
`include "clipped_rect_blit_rows_defines.svh"

module crb_dpath #(
    parameter int MAX_WIDTH  = crb_pkg::CRB_MAX_WIDTH,
    parameter int MAX_HEIGHT = crb_pkg::CRB_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  crb_pkg::t_uword             i_ctrl,
    output crb_pkg::t_stat              o_stat,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [crb_pkg::CRB_WW-1:0]  i_cfg_wdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [crb_pkg::CRB_IDW-1:0] i_s_tdata,
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [crb_pkg::CRB_ODW-1:0] o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);
    import crb_pkg::*;

    localparam int CW = CRB_CW;

    // Configuration.
    logic [CRB_WW-1:0] r_cfg_dw;
    logic [CRB_HW-1:0] r_cfg_dh;

    // Command fields, held for the whole command.
    logic              r_fill;
    logic [CRB_WW-1:0] r_sw, r_dw;
    logic [CRB_HW-1:0] r_sh, r_dh;
    logic signed [15:0] r_rx, r_ry, r_rw, r_rh, r_ox, r_oy;
    logic [31:0]       r_pix;

    // Shared axis temporaries.
    logic signed [CW-1:0] r_s0, r_s1, r_p, r_ln, r_d0, r_d1;
    logic                 r_empty_x;

    // Clipped placement.
    logic [CRB_WW-1:0] r_sx, r_dx, r_w;
    logic [CRB_HW-1:0] r_sy, r_dy, r_h;

    // Row emitter.
    logic [CRB_OW-1:0] r_src_off, r_dst_off;
    logic [CRB_HW-1:0] r_rows;

    // Output register.
    logic              r_out_valid;
    logic [CRB_OW-1:0] r_out_src, r_out_dst;
    logic [CRB_WW-1:0] r_out_run;
    logic              r_out_fill;
    logic [31:0]       r_out_pix;
    logic              r_out_last;

    logic [CRB_WW-1:0] w_sw_sat, w_dw_sat;
    logic [CRB_HW-1:0] w_sh_sat, w_dh_sat;
    logic signed [CW-1:0] w_r, w_n, w_o, w_lims, w_limd, w_rn, w_pl, w_len, w_start;
    logic w_s_fire, w_out_free, w_load, w_load_last;

    // Saturate sizes to the configured maxima.
    assign w_sw_sat = (32'(i_s_tdata[8:0]) > 32'(MAX_WIDTH)) ? CRB_WW'(MAX_WIDTH)
                                                                : i_s_tdata[8:0];
    assign w_sh_sat = (32'(i_s_tdata[15:9]) > 32'(MAX_HEIGHT)) ? CRB_HW'(MAX_HEIGHT)
                                                                 : i_s_tdata[15:9];
    assign w_dw_sat = (32'(r_cfg_dw) > 32'(MAX_WIDTH)) ? CRB_WW'(MAX_WIDTH) : r_cfg_dw;
    assign w_dh_sat = (32'(r_cfg_dh) > 32'(MAX_HEIGHT)) ? CRB_HW'(MAX_HEIGHT) : r_cfg_dh;

    assign o_s_tready = (i_ctrl.op == OP_WAIT);
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    // Axis operand selection for the shared clipping unit.
    assign w_r    = (i_ctrl.axis == AX_Y) ? CW'(r_ry) : CW'(r_rx);
    assign w_n    = (i_ctrl.axis == AX_Y) ? CW'(r_rh) : CW'(r_rw);
    assign w_o    = (i_ctrl.axis == AX_Y) ? CW'(r_oy) : CW'(r_ox);
    assign w_lims = (i_ctrl.axis == AX_Y) ? CW'(r_sh) : CW'(r_sw);
    assign w_limd = (i_ctrl.axis == AX_Y) ? CW'(r_dh) : CW'(r_dw);
    assign w_rn   = w_r + w_n;
    assign w_pl   = r_p + r_ln;
    assign w_len  = r_d1 - r_d0;
    assign w_start = r_s0 + (r_d0 - r_p);

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_load      = (i_ctrl.op == OP_EMIT) && w_out_free;
    assign w_load_last = w_load && (r_rows == CRB_HW'(1));

    assign o_stat.in_valid  = i_s_tvalid;
    assign o_stat.empty     = r_empty_x || (w_len <= 0);
    assign o_stat.rows_left = !w_load_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dw <= CRB_DST_WIDTH_RST;
            r_cfg_dh <= CRB_DST_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DST_WIDTH:  r_cfg_dw <= i_cfg_wdata;
                CFG_DST_HEIGHT: r_cfg_dh <= i_cfg_wdata[CRB_HW-1:0];
                default: ;
            endcase
        end
    end

    // Command capture and the clipping steps.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_WAIT: begin
                if (w_s_fire) begin
                    r_fill <= i_s_tuser;
                    r_sw   <= w_sw_sat;
                    r_sh   <= w_sh_sat;
                    r_dw   <= w_dw_sat;
                    r_dh   <= w_dh_sat;
                    r_rx   <= i_s_tdata[31:16];
                    r_ry   <= i_s_tdata[47:32];
                    r_rw   <= i_s_tdata[63:48];
                    r_rh   <= i_s_tdata[79:64];
                    r_ox   <= i_s_tdata[95:80];
                    r_oy   <= i_s_tdata[111:96];
                    r_pix  <= i_s_tdata[143:112];
                end
            end
            OP_BOUND: begin
                // A fill skips the source clip: its source span is the request.
                if (r_fill) begin
                    r_s0 <= w_r;
                    r_s1 <= w_rn;
                end else begin
                    r_s0 <= (w_r > 0) ? w_r : '0;
                    r_s1 <= (w_rn < w_lims) ? w_rn : w_lims;
                end
            end
            OP_PLACE: begin
                r_p  <= r_fill ? w_r : (w_o - w_r + r_s0);
                r_ln <= r_s1 - r_s0;
            end
            OP_DEST: begin
                r_d0 <= (r_p > 0) ? r_p : '0;
                r_d1 <= (w_pl < w_limd) ? w_pl : w_limd;
            end
            OP_TRIM: begin
                if (i_ctrl.axis == AX_Y) begin
                    r_sy <= w_start[CRB_HW-1:0];
                    r_dy <= r_d0[CRB_HW-1:0];
                    r_h  <= w_len[CRB_HW-1:0];
                end else begin
                    r_sx      <= w_start[CRB_WW-1:0];
                    r_dx      <= r_d0[CRB_WW-1:0];
                    r_w       <= w_len[CRB_WW-1:0];
                    r_empty_x <= (w_len <= 0);
                end
            end
            OP_MUL: begin
                r_src_off <= CRB_OW'(r_sy) * CRB_OW'(r_sw);
                r_dst_off <= CRB_OW'(r_dy) * CRB_OW'(r_dw);
            end
            OP_BASE: begin
                r_src_off <= r_src_off + CRB_OW'(r_sx);
                r_dst_off <= r_dst_off + CRB_OW'(r_dx);
            end
            OP_EMIT: begin
                if (w_load) begin
                    r_src_off <= r_src_off + CRB_OW'(r_sw);
                    r_dst_off <= r_dst_off + CRB_OW'(r_dw);
                end
            end
            default: ;
        endcase
    end

    // Row count is control state: it must read zero between commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else if (i_ctrl.op == OP_MUL) begin
            r_rows <= r_h;
        end else if (w_load) begin
            r_rows <= r_rows - CRB_HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_src  <= r_fill ? '0 : r_src_off;
            r_out_dst  <= r_dst_off;
            r_out_run  <= r_w;
            r_out_fill <= r_fill;
            r_out_pix  <= r_fill ? r_pix : '0;
            r_out_last <= (r_rows == CRB_HW'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_pix, r_out_run, r_out_dst, r_out_src};
    assign o_m_tuser  = r_out_fill;
    assign o_m_tlast  = r_out_last;

    `CRB_ASSERT_SAME(a_accept_idle, w_s_fire, r_rows == '0, "command accepted with rows pending")
    `CRB_ASSERT_NEXT(a_last_ends, w_load_last, !w_load, "beat loaded after the final row")
    `CRB_ASSERT_NEXT(a_run_nonzero, w_load, r_out_valid && (r_out_run != '0), "zero-length row")

endmodule

[hw/rtl/clipped_rect_blit_rows.sv]
// Clipped rectangle copy/fill row generator.
// A command beat on the slave channel (tuser = mode, 1 for fill) describes a
// copy from a source image or a fill; the block clips a copy against the source
// and every command against the destination size held in two configuration registers, then
// sends one row descriptor per surviving row on the master channel, top row
// first, with tlast on the final row. A command that clips to nothing sends
// no beat at all.
// Sequencing: a command is taken only while the control program waits at its
// first step. The clipping steps run one after another (bound, place, dest
// and trim for x, then for y, then multiply and base), after which one row
// leaves per cycle while the receiver keeps tready high; a command that clips
// to nothing returns to the wait step after the y trim. The block takes no
// new command until the last row of the current one is loaded, as the single
// shared clipping unit is stepped by the control store.
// When the receiver stalls, the held descriptor stays put and the program
// waits at its emit step. Reset returns the program to its wait step, drops
// tvalid and sets the destination to 256 x 64; there is no clearing pass.
module clipped_rect_blit_rows #(
    parameter int MAX_WIDTH  = crb_pkg::CRB_MAX_WIDTH,
    parameter int MAX_HEIGHT = crb_pkg::CRB_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [crb_pkg::CRB_WW-1:0]  i_cfg_wdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // src_width[8:0], src_height[15:9], rect_x[31:16], rect_y[47:32],
    // rect_w[63:48], rect_h[79:64], shift_x[95:80], shift_y[111:96],
    // fill_value[143:112]
    input  logic [crb_pkg::CRB_IDW-1:0] i_s_tdata,
    input  logic                        i_s_tuser,  // mode
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // src_offset[13:0], dst_offset[27:14], run_length[36:28],
    // pixel_value[68:37], zero[71:69]
    output logic [crb_pkg::CRB_ODW-1:0] o_m_tdata,
    output logic                        o_m_tuser,  // is_fill
    output logic                        o_m_tlast   // last_row
);
    import crb_pkg::*;

    t_uword w_ctrl;
    t_stat  w_stat;

    crb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    crb_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

[tb/sv/clipped_rect_blit_rows_tb.sv]
`timescale 1ns / 1ps

module clipped_rect_blit_rows_tb;

    import crb_pkg::*;

    localparam logic MODE_COPY = 1'b0;
    localparam logic MODE_FILL = 1'b1;
    localparam int   QUIET_LIMIT = 1000;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   CHUNK_CMDS = 25;
    localparam int   NUM_CHUNKS = 8;
    localparam int   CFG_WIDTHS[NUM_CHUNKS]  = '{511, 100, 0, 256, 37, 1, 255, 256};
    localparam int   CFG_HEIGHTS[NUM_CHUNKS] = '{127, 30, 64, 0, 5, 1, 63, 64};

    typedef struct {
        logic               mode;
        logic [8:0]         src_w;
        logic [6:0]         src_h;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
        logic [31:0]        fill_value;
    } t_blit_cmd;

    typedef struct {
        logic [13:0] src_off;
        logic [13:0] dst_off;
        logic [8:0]  run;
        logic        is_fill;
        logic [31:0] pixel;
        logic        last;
    } t_row_desc;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_idx;
    logic [CRB_WW-1:0]   i_cfg_wdata;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [CRB_IDW-1:0]  i_s_tdata;
    logic                i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [CRB_ODW-1:0]  o_m_tdata;
    logic                o_m_tuser;
    logic                o_m_tlast;

    t_blit_cmd cmd_queue[$];
    t_row_desc expected_rows[$];
    t_blit_cmd cur_cmd;
    logic [8:0] dst_w;
    logic [6:0] dst_h;
    bit  s_fire = 1'b0;
    int  send_idle;
    int  recv_idle;
    int  cmds_issued = 0;
    int  cmds_taken = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    clipped_rect_blit_rows u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    // Clips one command and queues a descriptor for each row that survives.
    function automatic void plan_rows(input t_blit_cmd c);
        longint dw, dh, sw, sh, rx, ry, rw, rh;
        longint x0, y0, x1, y1, px, py, dx, dy, ex, ey, sx, sy, w, h, y;
        t_row_desc r;
        dw = lmin(longint'(dst_w), longint'(CRB_MAX_WIDTH));
        dh = lmin(longint'(dst_h), longint'(CRB_MAX_HEIGHT));
        sw = lmin(longint'(c.src_w), longint'(CRB_MAX_WIDTH));
        sh = lmin(longint'(c.src_h), longint'(CRB_MAX_HEIGHT));
        rx = longint'(c.rect_x);
        ry = longint'(c.rect_y);
        rw = longint'(c.rect_w);
        rh = longint'(c.rect_h);
        sx = 0;
        sy = 0;
        if (rw <= 0 || rh <= 0)
            return;
        if (c.mode == MODE_FILL) begin
            sw = dw;
            sh = dh;
        end
        x0 = lmax(rx, 0);
        y0 = lmax(ry, 0);
        x1 = lmin(rx + rw, sw);
        y1 = lmin(ry + rh, sh);
        if (x1 <= x0 || y1 <= y0)
            return;
        if (c.mode == MODE_FILL) begin
            dx = x0;
            dy = y0;
            ex = x1;
            ey = y1;
        end else begin
            // The paste origin moves by whatever the source clip cut off.
            px = longint'(c.shift_x) + (x0 - rx);
            py = longint'(c.shift_y) + (y0 - ry);
            dx = lmax(px, 0);
            dy = lmax(py, 0);
            ex = lmin(px + (x1 - x0), dw);
            ey = lmin(py + (y1 - y0), dh);
            if (ex <= dx || ey <= dy)
                return;
            sx = x0 + (dx - px);
            sy = y0 + (dy - py);
        end
        w = ex - dx;
        h = ey - dy;
        for (y = 0; y < h; y++) begin
            r.src_off = (c.mode == MODE_FILL) ? 14'd0 : 14'((sy + y) * sw + sx);
            r.dst_off = 14'((dy + y) * dw + dx);
            r.run     = 9'(w);
            r.is_fill = c.mode;
            r.pixel   = (c.mode == MODE_FILL) ? c.fill_value : 32'd0;
            r.last    = (y == h - 1);
            expected_rows.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Row beats are checked before the command beat of the same edge is planned.
    always @(posedge i_clk) begin : monitor
        t_row_desc want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_rows.size() == 0) begin
                    $error("row beat 0x%0h arrived with no row expected", o_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("src_offset", longint'(want.src_off),
                                longint'(o_m_tdata[13:0]));
                    check_field("dst_offset", longint'(want.dst_off),
                                longint'(o_m_tdata[27:14]));
                    check_field("run_length", longint'(want.run),
                                longint'(o_m_tdata[36:28]));
                    check_field("pixel_value", longint'(want.pixel),
                                longint'(o_m_tdata[68:37]));
                    check_field("is_fill", longint'(want.is_fill), longint'(o_m_tuser));
                    check_field("last_row", longint'(want.last), longint'(o_m_tlast));
                end
            end
            s_fire = i_s_tvalid && o_s_tready;
            if (s_fire) begin
                plan_rows(cur_cmd);
                cmds_taken++;
            end
            if (s_fire || (o_m_tvalid && i_m_tready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin : driver
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= recv_idle);
            if (i_s_tvalid && !s_fire) begin
                // Beat still waiting for tready: hold it.
            end else if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
                cur_cmd = cmd_queue.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {cur_cmd.fill_value, cur_cmd.shift_y, cur_cmd.shift_x,
                               cur_cmd.rect_h, cur_cmd.rect_w, cur_cmd.rect_y,
                               cur_cmd.rect_x, cur_cmd.src_h, cur_cmd.src_w};
                i_s_tuser  <= cur_cmd.mode;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    task automatic add_cmd(input logic mode, input int sw, input int sh,
                           input int rx, input int ry, input int rw, input int rh,
                           input int ox, input int oy, input logic [31:0] fv);
        t_blit_cmd c;
        c.mode       = mode;
        c.src_w      = 9'(sw);
        c.src_h      = 7'(sh);
        c.rect_x     = 16'(rx);
        c.rect_y     = 16'(ry);
        c.rect_w     = 16'(rw);
        c.rect_h     = 16'(rh);
        c.shift_x    = 16'(ox);
        c.shift_y    = 16'(oy);
        c.fill_value = fv;
        cmd_queue.push_back(c);
        cmds_issued++;
    endtask

    // Mostly values near the image, now and then any 16-bit value.
    function automatic logic signed [15:0] pick_coord(input int lo, input int hi);
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic add_random_cmd();
        t_blit_cmd c;
        c.mode       = 1'($urandom_range(1));
        c.src_w      = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(1, 256));
        c.src_h      = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
        c.rect_x     = pick_coord(-40, 300);
        c.rect_y     = pick_coord(-20, 90);
        c.rect_w     = pick_coord(-4, 280);
        c.rect_h     = pick_coord(-2, 70);
        c.shift_x    = pick_coord(-40, 300);
        c.shift_y    = pick_coord(-20, 90);
        c.fill_value = $urandom;
        cmd_queue.push_back(c);
        cmds_issued++;
    endtask

    // Holds the sender back until every row is in and the block has gone quiet.
    task automatic drain();
        while (cmds_taken != cmds_issued || expected_rows.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [8:0] w, input logic [6:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_DST_WIDTH;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_DST_HEIGHT;
        i_cfg_wdata <= 9'(h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dst_w = w;
        dst_h = h;
    endtask

    initial begin
        int chunk;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_DST_WIDTH;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = MODE_COPY;
        i_m_tready  = 1'b0;
        dst_w       = CRB_DST_WIDTH_RST;
        dst_h       = CRB_DST_HEIGHT_RST;
        send_idle   = 34;
        recv_idle   = 66;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands against the reset destination of 256 x 64.
        add_cmd(MODE_FILL, 0, 0, 0, 0, 256, 64, 0, 0, 32'hFFFF_FFFF);
        add_cmd(MODE_FILL, 0, 0, 3, 3, 0, 5, 0, 0, 32'h1234_5678);
        add_cmd(MODE_FILL, 0, 0, 3, 3, -32768, -1, 0, 0, 32'h1);
        add_cmd(MODE_FILL, 0, 0, -32768, -32768, 32767, 32767, 0, 0, 32'h2);
        add_cmd(MODE_FILL, 0, 0, -10, -5, 20, 10, 0, 0, 32'hA5A5_5A5A);
        add_cmd(MODE_FILL, 0, 0, 250, 60, 32767, 32767, 0, 0, 32'h8000_0001);
        add_cmd(MODE_FILL, 0, 0, 32767, 0, 1, 1, 0, 0, 32'h3);
        add_cmd(MODE_FILL, 0, 0, 7, 9, 1, 1, 0, 0, 32'h0);
        add_cmd(MODE_COPY, 256, 64, 0, 0, 256, 64, 0, 0, 32'hDEAD_BEEF);
        add_cmd(MODE_COPY, 511, 127, -5, -3, 300, 100, 10, 4, 32'hFFFF_FFFF);
        add_cmd(MODE_COPY, 0, 64, 0, 0, 10, 10, 0, 0, 32'h0);
        add_cmd(MODE_COPY, 256, 0, 0, 0, 10, 10, 0, 0, 32'h0);
        add_cmd(MODE_COPY, 256, 64, 0, 0, 10, 10, -32768, 32767, 32'h0);
        add_cmd(MODE_COPY, 50, 20, 5, 5, 10, 10, -3, -2, 32'h0);
        add_cmd(MODE_COPY, 100, 50, 0, 0, 20, 20, 250, 60, 32'h0);
        add_cmd(MODE_COPY, 256, 64, 32767, 32767, 32767, 32767, 0, 0, 32'h0);
        add_cmd(MODE_COPY, 256, 64, -32768, -32768, 32767, 32767, 0, 0, 32'h0);
        add_cmd(MODE_COPY, 1, 1, 0, 0, 1, 1, 255, 63, 32'h0);
        add_cmd(MODE_COPY, 256, 64, 0, 0, 256, 1, 0, 63, 32'h0);
        add_cmd(MODE_COPY, 256, 64, 0, 0, 10, 10, 32767, 0, 32'h0);
        add_cmd(MODE_COPY, 256, 64, 0, 0, -1, 10, 0, 0, 32'h0);
        add_cmd(MODE_COPY, 120, 40, -20, 30, 200, 30, 40, -10, 32'h7);
        drain();

        for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            if (chunk < 3) begin
                send_idle = 34;
                recv_idle = 66;
            end else if (chunk < 6) begin
                send_idle = 66;
                recv_idle = 34;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_cfg(9'(CFG_WIDTHS[chunk]), 7'(CFG_HEIGHTS[chunk]));
            repeat (CHUNK_CMDS) add_random_cmd();
            drain();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
